// File: src/spq_pkg.sv
// Shared constants, types and status codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// File: src/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps

interface spq_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, output action, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input action, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_resp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic [1:0]         status;
    logic [4:0]         occupancy;

    modport source (output valid, output out_value, output out_priority, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_value, input out_priority, input status,
                    input occupancy, output ready);
endinterface

// File: src/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps

module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_ge,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               ge
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Empty slots count as "greater", so the insert point falls on the tail.
    assign ge    = !occupied || (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (left_ge)
                entry_next = left_entry;
            else if (ge)
                entry_next = new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: src/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count and response register.
// Response: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell decides its shift locally, so the
// chain takes a push or pop each clock while the response is drained.
// Reset: rst_n (asynchronous, active low) empties the queue and drops any pending
// response; slot contents are not cleared and are never read while empty.
`timescale 1ns / 1ps

module sorted_priority_queue (
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink    req,
    spq_resp_if.source resp
);
    import spq_pkg::*;

    // Count of stored entries; slot i is live when i < count.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Response register, parts the request side from the response side.
    logic                     resp_valid_reg;
    logic signed [DATA_W-1:0] resp_value_reg;
    logic signed [DATA_W-1:0] resp_priority_reg;
    logic [STATUS_W-1:0]      resp_status_reg;
    logic [OCC_W-1:0]         resp_occ_reg;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic [STATUS_W-1:0] status_next;
    cell_ctrl_t         ctrl;
    entry_t             new_entry;

    entry_t     cell_entry [CAPACITY];
    logic       cell_ge    [CAPACITY];
    logic       cell_occ   [CAPACITY];

    // A new request is taken whenever the response slot is free or being emptied.
    assign req.ready = !resp_valid_reg || resp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign new_entry.value = req.item_value;
    assign new_entry.prio  = req.item_priority;

    // Rejected requests leave the chain alone.
    assign ctrl.push = accept && (req.action == ACT_PUSH) && !is_full;
    assign ctrl.pop  = accept && (req.action == ACT_POP) && !is_empty;

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (ctrl.push)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - CNT_W'(1);
        if (req.action == ACT_POP && is_empty)
            status_next = ST_EMPTY;
        else if (req.action == ACT_PUSH && is_full)
            status_next = ST_FULL;
    end

    // The chain: each cell sees its left neighbour's entry and insert flag on a
    // push, and its right neighbour's entry on a pop.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        logic   left_g;
        entry_t right_e;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_g = cell_ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                resp_valid_reg <= 1'b1;
            else if (resp.ready)
                resp_valid_reg <= 1'b0;
        end
    end

    // Payload: the head is returned on a successful pop, zero otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            resp_value_reg    <= ctrl.pop ? cell_entry[0].value : '0;
            resp_priority_reg <= ctrl.pop ? cell_entry[0].prio : '0;
            resp_status_reg   <= status_next;
            resp_occ_reg      <= OCC_W'(count_next);
        end
    end

    assign resp.valid        = resp_valid_reg;
    assign resp.out_value    = resp_value_reg;
    assign resp.out_priority = resp_priority_reg;
    assign resp.status       = resp_status_reg;
    assign resp.occupancy    = resp_occ_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_POP && is_empty)
        |=> (resp.valid && resp.status == ST_EMPTY && count_reg == '0))
        else $error("pop on empty queue not flagged");

    a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the queue");

    a_head_order : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2))
        |-> (cell_entry[0].prio <= cell_entry[1].prio))
        else $error("head entries out of order");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the sorted priority queue: directed edges, biased random traffic, a pause.
`timescale 1ns / 1ps

module tb;

    // Result fields of one request, as the queue should report them.
    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if  req_ch ();
    spq_resp_if resp_ch ();

    sorted_priority_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .resp  (resp_ch.source)
    );

    // Shadow copy of the queue contents, kept in ascending order of priority.
    logic signed [31:0] shadow_value [spq_pkg::CAPACITY];
    logic signed [31:0] shadow_prio  [spq_pkg::CAPACITY];
    int                 shadow_count;

    // Results owed by the block, oldest first.
    queue_result_t awaited_results[$];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;

    always #2 clk = ~clk;

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Work out what one accepted request does to the queue and what it reports.
    function automatic queue_result_t apply_queue_request(input logic act,
                                                          input logic signed [31:0] val,
                                                          input logic signed [31:0] pri);
        queue_result_t res;
        int            slot;
        res.value  = '0;
        res.prio   = '0;
        res.status = spq_pkg::ST_OK;
        if (act == spq_pkg::ACT_PUSH)
        begin
            if (shadow_count >= spq_pkg::CAPACITY)
                res.status = spq_pkg::ST_FULL;
            else
            begin
                // New entry lands in front of the first one with priority >= its own,
                // so ties leave newest first; otherwise it goes to the tail.
                slot = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_prio[i] >= pri)
                    begin
                        slot = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > slot; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[slot] = val;
                shadow_prio[slot]  = pri;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                res.status = spq_pkg::ST_EMPTY;
            else
            begin
                res.value = shadow_value[0];
                res.prio  = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        res.occupancy = shadow_count[4:0];
        return res;
    endfunction

    // Drive one request from a falling edge and hold it until it is taken.
    // Returns at the falling edge after acceptance with valid still high, so
    // back-to-back requests need no extra assignment in the same step.
    task automatic send_request(input logic act,
                                input logic signed [31:0] val,
                                input logic signed [31:0] pri);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.action        = act;
        req_ch.item_value    = val;
        req_ch.item_priority = pri;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_results.push_back(apply_queue_request(act, val, pri));
        @(negedge clk);
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_until_drained();
        req_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // Pop on empty, ties at both ends, tail appends, fill to capacity, push on full, then pops from the head.
    task automatic test_directed_edges();
        send_request(spq_pkg::ACT_POP, 32'sd77, 32'sd77);
        send_request(spq_pkg::ACT_PUSH, 32'sd1, 32'sd0);
        send_request(spq_pkg::ACT_PUSH, 32'sd2, 32'sd10);
        send_request(spq_pkg::ACT_PUSH, 32'sd3, 32'sd10);
        send_request(spq_pkg::ACT_PUSH, 32'sd4, -32'sd5);
        send_request(spq_pkg::ACT_PUSH, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(spq_pkg::ACT_PUSH, 32'h8000_0000, 32'h8000_0000);
        send_request(spq_pkg::ACT_PUSH, 32'sd5, 32'h7fff_ffff);
        send_request(spq_pkg::ACT_PUSH, 32'sd6, 32'h8000_0000);
        send_request(spq_pkg::ACT_PUSH, -32'sd1, -32'sd1);
        send_request(spq_pkg::ACT_PUSH, 32'sd0, 32'sd1);
        send_request(spq_pkg::ACT_PUSH, 32'sd7, 32'sd5);
        send_request(spq_pkg::ACT_PUSH, 32'sd8, 32'sd5);
        send_request(spq_pkg::ACT_PUSH, 32'sd9, -32'sd100);
        send_request(spq_pkg::ACT_PUSH, 32'sd10, 32'sd1000);
        send_request(spq_pkg::ACT_PUSH, 32'sd11, 32'sd0);
        send_request(spq_pkg::ACT_PUSH, 32'sd12, 32'sd0);
        // queue is full now; this one must be dropped
        send_request(spq_pkg::ACT_PUSH, 32'sd13, 32'sd3);
        repeat (4)
            send_request(spq_pkg::ACT_POP, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    // Random requests in bursts that lean towards filling or draining, so the
    // queue swings between empty and full many times.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        logic               act;
        logic signed [31:0] val;
        logic signed [31:0] pri;
        int                 push_pct;
        int                 burst_left;
        int                 pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        push_pct       = 75;
        burst_left     = $urandom_range(60, 20);
        for (int k = 0; k < n_items; k++)
        begin
            if (burst_left == 0)
            begin
                push_pct   = (push_pct == 75) ? 25 : 75;
                burst_left = $urandom_range(60, 20);
            end
            burst_left--;
            act  = ($urandom_range(99) < push_pct) ? spq_pkg::ACT_PUSH : spq_pkg::ACT_POP;
            val  = $urandom;
            pick = $urandom_range(9);
            if (pick < 4)
                pri = $signed($urandom_range(7)) - 4;   // narrow range, plenty of ties
            else if (pick == 4)
            begin
                case ($urandom_range(3))
                    0:       pri = 32'h8000_0000;
                    1:       pri = 32'h7fff_ffff;
                    2:       pri = -32'sd1;
                    default: pri = 32'sd0;
                endcase
            end
            else
                pri = $urandom;
            send_request(act, val, pri);
        end
    endtask

    // Sender stops dead until the block has answered everything, then resumes.
    task automatic test_pause_and_resume();
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        wait_until_drained();
        repeat (3)
            send_request(spq_pkg::ACT_PUSH, $urandom, $urandom);
        send_request(spq_pkg::ACT_POP, $urandom, $urandom);
    endtask

    // Response side: random back-pressure, changed on the falling edge.
    always @(negedge clk)
        resp_ch.ready = ($urandom_range(99) >= recv_stall_pct);

    // Compare each accepted response with the oldest owed result.
    always @(posedge clk)
    begin
        queue_result_t exp;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected response value=%0d prio=%0d status=%0d occ=%0d",
                         $time, resp_ch.out_value, resp_ch.out_priority,
                         resp_ch.status, resp_ch.occupancy);
                error_count++;
            end
            else
            begin
                exp = awaited_results.pop_front();
                if (resp_ch.out_value !== exp.value)
                begin
                    $display("%0t: out_value expected %0d got %0d",
                             $time, exp.value, resp_ch.out_value);
                    error_count++;
                end
                if (resp_ch.out_priority !== exp.prio)
                begin
                    $display("%0t: out_priority expected %0d got %0d",
                             $time, exp.prio, resp_ch.out_priority);
                    error_count++;
                end
                if (resp_ch.status !== exp.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, exp.status, resp_ch.status);
                    error_count++;
                end
                if (resp_ch.occupancy !== exp.occupancy)
                begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, exp.occupancy, resp_ch.occupancy);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        error_count          = 0;
        shadow_count         = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        req_ch.valid         = 1'b0;
        req_ch.action        = spq_pkg::ACT_PUSH;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        resp_ch.ready        = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_random_traffic(300, 0, 0);
        test_pause_and_resume();
        test_random_traffic(300, 51, 0);
        test_random_traffic(300, 0, 51);
        test_random_traffic(300, 14, 14);

        // Let the last responses come home, then a short quiet window to catch strays.
        req_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
